// ----- hw/rtl/ipd_pkg.sv -----
// Shared types and constants for the packet line deframer.
// Used by the channel interfaces, the step logic and the top level.
`default_nettype none
package ipd_pkg;

  localparam int COUNT_W    = 20;
  localparam int DIGIT_W    = 3;
  localparam int LINE_IDX_W = 5;
  localparam int COL_IDX_W  = 6;
  localparam int BYTE_W     = 8;

  localparam int LINES_DEF      = 32;
  localparam int CHARS_DEF      = 64;
  localparam int MAX_DIGITS_DEF = 6;

  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COUNT   = 2'd1,
    MODE_PAYLOAD = 2'd2
  } ipd_mode_t;

  typedef struct packed {
    ipd_mode_t          mode;
    logic [COUNT_W-1:0] count;
    logic [DIGIT_W-1:0] digits;
  } ipd_ctrl_t;

  typedef struct packed {
    logic                  store_valid;
    logic [LINE_IDX_W-1:0] line_index;
    logic [COL_IDX_W-1:0]  column_index;
    logic [BYTE_W-1:0]     store_char;
    logic                  frame_end;
  } ipd_result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ipd_if.sv -----
// Valid/ready channel interfaces for received bytes and line store writes.
// Depends on ipd_pkg for field widths.
`default_nettype none
interface ipd_rx_if import ipd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ipd_wr_if import ipd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  store_valid;
  logic [LINE_IDX_W-1:0] line_index;
  logic [COL_IDX_W-1:0]  column_index;
  logic [BYTE_W-1:0]     store_char;
  logic                  frame_end;

  modport source (output valid, output store_valid, output line_index,
                  output column_index, output store_char, output frame_end,
                  input ready);
  modport sink (input valid, input store_valid, input line_index,
                input column_index, input store_char, input frame_end,
                output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ipd_step.sv -----
// Per-byte parser update: next mode, count, position and the store write.
// Depends on ipd_pkg.
`default_nettype none
module ipd_step import ipd_pkg::*; #(
  parameter int LINES      = LINES_DEF,
  parameter int CHARS      = CHARS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  localparam int LW        = (LINES > 1) ? $clog2(LINES) : 1,
  localparam int CW        = $clog2(CHARS)
) (
  input  wire ipd_ctrl_t         ctrl,
  input  wire logic [LW-1:0]     line,
  input  wire logic [CW-1:0]     col,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output ipd_ctrl_t              ctrl_next,
  output logic [LW-1:0]          line_next,
  output logic [CW-1:0]          col_next,
  output ipd_result_t            res
);

  localparam int LEW = (LW > LINE_IDX_W) ? LW : LINE_IDX_W;
  localparam int CEW = (CW > COL_IDX_W) ? CW : COL_IDX_W;

  logic [COUNT_W-1:0] count_acc;
  logic [COUNT_W-1:0] count_dec;
  logic [LEW-1:0]     line_ext;
  logic [CEW-1:0]     col_ext;

  assign count_acc = {ctrl.count[COUNT_W-4:0], 3'b000} + {ctrl.count[COUNT_W-2:0], 1'b0}
                   + {{(COUNT_W-BYTE_W){1'b0}}, rx_byte}
                   - {{(COUNT_W-BYTE_W){1'b0}}, CHAR_ZERO};
  assign count_dec = ctrl.count - COUNT_W'(1);
  assign line_ext  = LEW'(line);
  assign col_ext   = CEW'(col);

  always_comb begin
    ctrl_next = ctrl;
    line_next = line;
    col_next  = col;
    res       = '0;
    case (ctrl.mode)
      MODE_COUNT: begin
        if (rx_byte == CHAR_COLON) begin
          ctrl_next.mode   = MODE_PAYLOAD;
          ctrl_next.digits = '0;
        end else if (ctrl.digits < DIGIT_W'(MAX_DIGITS)) begin
          ctrl_next.count  = count_acc;
          ctrl_next.digits = ctrl.digits + DIGIT_W'(1);
        end
      end
      MODE_PAYLOAD: begin
        if (rx_byte != CHAR_CR) begin
          res.store_valid  = 1'b1;
          res.line_index   = line_ext[LINE_IDX_W-1:0];
          res.column_index = col_ext[COL_IDX_W-1:0];
          if (ctrl.count != '0) begin
            res.store_char  = rx_byte;
            ctrl_next.count = count_dec;
            if (rx_byte == CHAR_LF) begin
              if (count_dec != '0) begin
                ctrl_next.count = count_dec - COUNT_W'(1);
              end
              col_next = '0;
              if (line < LW'(LINES - 1)) begin
                line_next = line + LW'(1);
              end
            end else if (col == CW'(CHARS - 1)) begin
              col_next = '0;
            end else begin
              col_next = col + CW'(1);
            end
          end else begin
            res.store_char = CHAR_LF;
            res.frame_end  = 1'b1;
            ctrl_next.mode = MODE_IDLE;
            line_next      = '0;
            col_next       = '0;
          end
        end
      end
      default: begin
        ctrl_next.mode = MODE_IDLE;
        if (rx_byte == CHAR_COMMA) begin
          ctrl_next.mode   = MODE_COUNT;
          ctrl_next.count  = '0;
          ctrl_next.digits = '0;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ipd_packet_line_deframer_top.sv -----
// Top level of the packet line deframer: parser state and result register.
// Depends on ipd_pkg, ipd_if and ipd_step.
`default_nettype none
// Takes one received byte per transfer and returns exactly one result per byte,
// registered when the byte is taken. A byte can be taken every clock: the next
// parser state is combinational and the result register frees as soon as its
// transfer completes, so throughput is one byte per cycle while the store side
// keeps up. A result with store_valid low carries all-zero fields. No clearing
// pass follows reset.
module ipd_packet_line_deframer_top import ipd_pkg::*; #(
  parameter int LINES      = LINES_DEF,
  parameter int CHARS      = CHARS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ipd_rx_if.sink   rx,
  ipd_wr_if.source wr
);

  localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CW = $clog2(CHARS);

  ipd_ctrl_t   ctrl;
  ipd_ctrl_t   ctrl_next;
  logic [LW-1:0] line;
  logic [LW-1:0] line_next;
  logic [CW-1:0] col;
  logic [CW-1:0] col_next;
  ipd_result_t res;
  ipd_result_t res_next;
  logic        wr_valid;
  logic        take;

  assign rx.ready = !wr_valid || wr.ready;
  assign take     = rx.valid && rx.ready;

  ipd_step #(
    .LINES      (LINES),
    .CHARS      (CHARS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_step (
    .ctrl      (ctrl),
    .line      (line),
    .col       (col),
    .rx_byte   (rx.rx_byte),
    .ctrl_next (ctrl_next),
    .line_next (line_next),
    .col_next  (col_next),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl     <= '{mode: MODE_IDLE, count: '0, digits: '0};
      line     <= '0;
      col      <= '0;
      wr_valid <= 1'b0;
    end else begin
      if (take) begin
        ctrl <= ctrl_next;
        line <= line_next;
        col  <= col_next;
      end
      if (take) begin
        wr_valid <= 1'b1;
      end else if (wr.ready) begin
        wr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign wr.valid        = wr_valid;
  assign wr.store_valid  = res.store_valid;
  assign wr.line_index   = res.line_index;
  assign wr.column_index = res.column_index;
  assign wr.store_char   = res.store_char;
  assign wr.frame_end    = res.frame_end;

`ifndef SYNTHESIS
  a_end_is_store: assert property (@(posedge clk) disable iff (rst)
    (wr_valid && res.frame_end) |-> res.store_valid)
    else $error("frame end without a store write");

  a_idle_blank: assert property (@(posedge clk) disable iff (rst)
    (wr_valid && !res.store_valid) |-> (res == '0))
    else $error("non-write result carries data");

  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (take && res_next.frame_end) |=> (ctrl.mode == MODE_IDLE && line == '0 && col == '0))
    else $error("frame close did not return to idle");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.digits <= DIGIT_W'(MAX_DIGITS))
    else $error("digit counter beyond limit");
`endif

endmodule
`default_nettype wire
